### hdl/spg_pkg.sv
// Shared types, codes and constants of the stepper pulse generator.
// No dependencies; imported by the pulse generator core.
`default_nettype none

package spg_pkg;

    // Request kinds carried in the slave-side tuser bit
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Motor selection codes
    localparam logic [1:0] MODE_WEIGH = 2'd1;
    localparam logic [1:0] MODE_STORE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SPEED_INDEX     = 1'b0;
    localparam logic CFG_SENSORS_ENABLED = 1'b1;

    // Run constants
    localparam logic [3:0] SPEED_ENTRIES  = 4'd10;
    localparam logic [5:0] STARTUP_PULSES = 6'd25;
    localparam logic [7:0] EXTRA_PULSES   = 8'd2;
    localparam logic [7:0] SENSOR_WINDOW  = 8'd50;

    // Payload widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Input payload, last field in the lowest bits
    typedef struct packed {
        logic [2:0] pad;
        logic       store_closed;
        logic       weigh_closed;
        logic       keep_power;
        logic [7:0] pulse_count;
        logic [1:0] motor_mode;
    } in_data_t;

    // Result payload, last field in the lowest bits
    typedef struct packed {
        logic [1:0] pad;
        logic       store_fault;
        logic       weigh_fault;
        logic [7:0] pulses_remaining;
        logic       busy_res;
        logic       store_enable;
        logic       weigh_enable;
        logic       step_pulse;
    } out_data_t;

    // Tick counter reload per speed; out-of-range indexes use the last entry
    function automatic logic [7:0] speed_reload(input logic [3:0] idx);
        logic [7:0] val;
        begin
            case (idx)
                4'd0:    val = 8'hF0;
                4'd1:    val = 8'hF2;
                4'd2:    val = 8'hF4;
                4'd3:    val = 8'hF5;
                4'd4:    val = 8'hF6;
                4'd5:    val = 8'hF7;
                4'd6:    val = 8'hF8;
                4'd7:    val = 8'hF9;
                4'd8:    val = 8'hFA;
                default: val = 8'hFB;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

### hdl/stepper_pulse_generator_with_ramp_core.sv
// Stepper pulse generator core: start ramp, speed table reload, home sensor cut.
// Depends on spg_pkg for codes, payload structs and the speed table.
//
//  channel   | direction | content
//  ----------+-----------+----------------------------------------------
//  s_axis    | in        | tuser: op; tdata: mode, count, keep, sensors
//  m_axis    | out       | tdata: pulse, enables, busy, remaining, faults
//  cfg       | in        | register index and write data, no read-back
//
// One request per clock: the run state and the result register update in the
// same cycle the request is accepted, so a result appears in the cycle after.
// The single result register sets the rate; a new request is taken whenever
// that register is empty or being drained. rst_n clears the run state, the
// faults and the output valid; speed_index resets to 0, sensors_enabled to 1.
`default_nettype none

module stepper_pulse_generator_with_ramp_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [spg_pkg::IN_DATA_W-1:0] s_axis_tdata,  // mode[1:0] count[9:2] keep[10]
                                                              // weigh_closed[11] store_closed[12]
    input  wire logic                          s_axis_tuser,  // op[0]
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [spg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // pulse[0] weigh_en[1] store_en[2]
                                                              // busy[3] remaining[11:4]
                                                              // weigh_fault[12] store_fault[13]
    // configuration writes
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_addr,
    input  wire logic [3:0]                    cfg_wdata
);
    import spg_pkg::*;

    in_data_t   in_d;
    logic       in_fire;

    logic [3:0] speed_index_reg;
    logic       sensors_enabled_reg;

    logic [7:0] remaining_reg,    remaining_next;
    logic [5:0] ramp_left_reg,    ramp_left_next;
    logic       hold_power_reg,   hold_power_next;
    logic       closure_seen_reg, closure_seen_next;
    logic [1:0] active_mode_reg,  active_mode_next;
    logic       running_reg,      running_next;
    logic [7:0] tick_count_reg,   tick_count_next;
    logic       enable_weigh_reg, enable_weigh_next;
    logic       enable_store_reg, enable_store_next;
    logic       fault_weigh_reg,  fault_weigh_next;
    logic       fault_store_reg,  fault_store_next;
    logic       pulse;

    logic       out_valid_reg;
    out_data_t  out_data_reg, out_data_next;

    logic [7:0] tick_inc;
    logic [7:0] rem_dec;
    logic       in_window;
    logic       sensor_hit;

    assign in_d          = in_data_t'(s_axis_tdata);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_data_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_index_reg     <= 4'd0;
            sensors_enabled_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_SPEED_INDEX:     speed_index_reg     <= cfg_wdata;
                CFG_SENSORS_ENABLED: sensors_enabled_reg <= cfg_wdata[0];
                default:             ;
            endcase
        end
    end

    // Work out the run state after the current request
    assign tick_inc   = tick_count_reg + 8'd1;
    assign rem_dec    = remaining_reg - 8'd1;
    assign in_window  = (rem_dec > EXTRA_PULSES) && (rem_dec < SENSOR_WINDOW);
    assign sensor_hit = ((active_mode_reg == MODE_WEIGH) && in_d.weigh_closed) ||
                        ((active_mode_reg == MODE_STORE) && in_d.store_closed);

    always_comb
    begin
        remaining_next    = remaining_reg;
        ramp_left_next    = ramp_left_reg;
        hold_power_next   = hold_power_reg;
        closure_seen_next = closure_seen_reg;
        active_mode_next  = active_mode_reg;
        running_next      = running_reg;
        tick_count_next   = tick_count_reg;
        enable_weigh_next = enable_weigh_reg;
        enable_store_next = enable_store_reg;
        fault_weigh_next  = fault_weigh_reg;
        fault_store_next  = fault_store_reg;
        pulse             = 1'b0;

        if (s_axis_tuser == OP_START)
        begin
            // Load a new run; ignore it while the speed index is out of range
            if (speed_index_reg < SPEED_ENTRIES)
            begin
                remaining_next    = in_d.pulse_count;
                ramp_left_next    = STARTUP_PULSES;
                hold_power_next   = in_d.keep_power;
                closure_seen_next = 1'b0;
                active_mode_next  = in_d.motor_mode;
                enable_weigh_next = (in_d.motor_mode == MODE_WEIGH);
                enable_store_next = (in_d.motor_mode == MODE_STORE);
                tick_count_next   = speed_reload(speed_index_reg);
                running_next      = 1'b1;
            end
        end
        else if (running_reg)
        begin
            // Advance the tick counter; act only on wrap
            tick_count_next = tick_inc;
            if (tick_inc == 8'd0)
            begin
                if (remaining_reg != 8'd0)
                begin
                    // Issue a step and reload, slow during the start ramp
                    pulse          = 1'b1;
                    remaining_next = rem_dec;
                    if (ramp_left_reg != 6'd0)
                    begin
                        ramp_left_next  = ramp_left_reg - 6'd1;
                        tick_count_next = speed_reload(4'd0);
                    end
                    else
                    begin
                        tick_count_next = speed_reload(speed_index_reg);
                    end
                    // Cut the closing run short once home is seen
                    if (sensors_enabled_reg && !hold_power_reg)
                    begin
                        if (in_window && sensor_hit)
                            remaining_next = EXTRA_PULSES;
                        if (in_d.weigh_closed || in_d.store_closed)
                            closure_seen_next = 1'b1;
                    end
                end
                else
                begin
                    // End the run: record faults, drop enables unless held
                    if (sensors_enabled_reg)
                    begin
                        if (active_mode_reg == MODE_STORE)
                            fault_store_next = !closure_seen_reg;
                        if (active_mode_reg == MODE_WEIGH)
                            fault_weigh_next = !closure_seen_reg;
                    end
                    if (!hold_power_reg)
                    begin
                        enable_weigh_next = 1'b0;
                        enable_store_next = 1'b0;
                    end
                    running_next = 1'b0;
                end
            end
        end
    end

    // Pack the result
    always_comb
    begin
        out_data_next                  = '0;
        out_data_next.step_pulse       = pulse;
        out_data_next.weigh_enable     = enable_weigh_next;
        out_data_next.store_enable     = enable_store_next;
        out_data_next.busy_res         = running_next;
        out_data_next.pulses_remaining = remaining_next;
        out_data_next.weigh_fault      = fault_weigh_next;
        out_data_next.store_fault      = fault_store_next;
    end

    // Hold run state; advance it on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg    <= 8'd0;
            ramp_left_reg    <= 6'd0;
            hold_power_reg   <= 1'b0;
            closure_seen_reg <= 1'b0;
            active_mode_reg  <= 2'd0;
            running_reg      <= 1'b0;
            tick_count_reg   <= 8'd0;
            enable_weigh_reg <= 1'b0;
            enable_store_reg <= 1'b0;
            fault_weigh_reg  <= 1'b0;
            fault_store_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            remaining_reg    <= remaining_next;
            ramp_left_reg    <= ramp_left_next;
            hold_power_reg   <= hold_power_next;
            closure_seen_reg <= closure_seen_next;
            active_mode_reg  <= active_mode_next;
            running_reg      <= running_next;
            tick_count_reg   <= tick_count_next;
            enable_weigh_reg <= enable_weigh_next;
            enable_store_reg <= enable_store_next;
            fault_weigh_reg  <= fault_weigh_next;
            fault_store_reg  <= fault_store_next;
        end
    end

    // Result register valid: set on accept, drop when drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
